### src/salt_pkg.sv
// ---------------------------------------------------------------------------
// Stroke arc-length tracker package
// Shared widths, register indexes, stream field offsets and types.
// ---------------------------------------------------------------------------
`default_nettype none

package salt_pkg;

   // Point geometry
   localparam int COORD_BITS    = 16;
   localparam int MAX_DIMS      = 4;
   localparam int NUM_IN_COORDS = 4;
   localparam int DIFF_BITS     = COORD_BITS + 1;
   localparam int SQ_BITS       = 2 * COORD_BITS + $clog2(MAX_DIMS);
   localparam int DIM_IDX_BITS  = $clog2(MAX_DIMS);

   // Square root datapath
   localparam int ROOT_BITS     = (SQ_BITS + 1) / 2;
   localparam int RAD_BITS      = 2 * ROOT_BITS;
   localparam int REM_BITS      = ROOT_BITS + 3;
   localparam int ROOT_CNT_BITS = $clog2(ROOT_BITS);

   // Register and result field widths
   localparam int DIMS_BITS     = 3;
   localparam int MIN_SQ_BITS   = 36;
   localparam int INDEX_BITS    = 16;
   localparam int SEG_BITS      = 17;
   localparam int ARC_BITS      = 32;

   localparam logic [DIMS_BITS-1:0] DIMS_RESET = DIMS_BITS'(2);
   localparam logic [DIMS_BITS-1:0] DIMS_MIN   = DIMS_BITS'(2);

   // Configuration port
   localparam int CSR_INDEX_BITS = 1;
   localparam int CSR_DATA_BITS  = MIN_SQ_BITS;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_DIMS_IN_USE     = 1'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MIN_SQ_DISTANCE = 1'd1;

   // Stream packing
   localparam int REQ_TDATA_BITS = NUM_IN_COORDS * COORD_BITS;
   localparam int RSP_INDEX_LSB  = 0;
   localparam int RSP_SEG_LSB    = RSP_INDEX_LSB + INDEX_BITS;
   localparam int RSP_ARC_LSB    = RSP_SEG_LSB + SEG_BITS;
   localparam int RSP_USED_BITS  = RSP_ARC_LSB + ARC_BITS;
   localparam int RSP_TDATA_BITS = ((RSP_USED_BITS + 7) / 8) * 8;

   typedef logic signed [COORD_BITS-1:0] coord_type;
   typedef logic [SQ_BITS-1:0]           sq_type;

endpackage : salt_pkg

`default_nettype wire

### src/stroke_arc_length_tracker_top.sv
// ---------------------------------------------------------------------------
// Stroke arc-length tracker
// Follows a polyline stroke point by point: drops near duplicates, gives the
// integer segment length, the running arc length and the kept point index.
// ---------------------------------------------------------------------------
// Each point takes its own pass through a small sequencer built around one
// 16x16 multiplier and one bit-per-cycle square root unit. A stroke start goes
// straight to the result; a dropped point runs one multiply-accumulate per
// coordinate and one compare; a kept point adds 17 root steps and the load of
// the result. The result shows up in the same cycle as the input is ready
// again. The input is not ready while a point is in progress. A finished
// result sits in the output register and the next point can be taken
// meanwhile; a result that is still waiting there when the next point
// finishes holds that point until it leaves.
// Registers may be written at any time the block is idle; csr_ready is always
// high.
`default_nettype none

module stroke_arc_length_tracker_top (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   // Input points
   input  wire logic                                  req_tvalid,
   output      logic                                  req_tready,
   // coord_0 [15:0], coord_1 [31:16], coord_2 [47:32], coord_3 [63:48]
   input  wire logic [salt_pkg::REQ_TDATA_BITS-1:0]   req_tdata,
   // start_stroke [0]
   input  wire logic                                  req_tuser,
   // Results
   output      logic                                  rsp_tvalid,
   input  wire logic                                  rsp_tready,
   // point_index [15:0], segment_length [32:16], arc_length [64:33], zero [71:65]
   output      logic [salt_pkg::RSP_TDATA_BITS-1:0]   rsp_tdata,
   // accepted [0]
   output      logic                                  rsp_tuser,
   // Configuration writes
   input  wire logic                                  csr_valid,
   output      logic                                  csr_ready,
   input  wire logic [salt_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  wire logic [salt_pkg::CSR_DATA_BITS-1:0]    csr_wdata
);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_SQ   = 3'd1;
   localparam logic [2:0] ST_CMP  = 3'd2;
   localparam logic [2:0] ST_ROOT = 3'd3;
   localparam logic [2:0] ST_DONE = 3'd4;

   localparam logic [salt_pkg::ROOT_CNT_BITS-1:0] ROOT_LAST_CNT =
      salt_pkg::ROOT_CNT_BITS'(salt_pkg::ROOT_BITS - 1);
   localparam logic [salt_pkg::INDEX_BITS-1:0] INDEX_MAX = '1;

   // Control
   logic [2:0]                              state_ff, state_in;
   logic [salt_pkg::DIM_IDX_BITS-1:0]       dim_ff, dim_in;
   logic [salt_pkg::ROOT_CNT_BITS-1:0]      cnt_ff, cnt_in;
   logic                                    first_ff, first_in;
   logic                                    keep_ff, keep_in;
   logic                                    rsp_valid_ff, rsp_valid_in;

   // Configuration
   logic [salt_pkg::DIMS_BITS-1:0]          dims_ff, dims_in;
   logic [salt_pkg::MIN_SQ_BITS-1:0]        min_sq_ff, min_sq_in;

   // Stroke state
   salt_pkg::coord_type                     last_ff [salt_pkg::MAX_DIMS];
   salt_pkg::coord_type                     last_in [salt_pkg::MAX_DIMS];
   logic [salt_pkg::ARC_BITS-1:0]           run_ff, run_in;
   logic [salt_pkg::INDEX_BITS-1:0]         kept_ff, kept_in;

   // Working point and datapath
   salt_pkg::coord_type                     pt_ff [salt_pkg::MAX_DIMS];
   salt_pkg::coord_type                     pt_in [salt_pkg::MAX_DIMS];
   salt_pkg::sq_type                        acc_ff, acc_in;
   logic [salt_pkg::RAD_BITS-1:0]           rad_ff, rad_in;
   logic [salt_pkg::REM_BITS-1:0]           rem_ff, rem_in;
   logic [salt_pkg::ROOT_BITS-1:0]          root_ff, root_in;

   // Output register
   logic [salt_pkg::RSP_TDATA_BITS-1:0]     rsp_data_ff, rsp_data_in;
   logic                                    rsp_user_ff, rsp_user_in;

   // Combinational helpers
   logic [salt_pkg::DIMS_BITS-1:0]          dims_eff;
   logic [salt_pkg::DIM_IDX_BITS-1:0]       last_dim;
   logic signed [salt_pkg::DIFF_BITS-1:0]   diff;
   logic [salt_pkg::DIFF_BITS-1:0]          diff_abs;
   logic [salt_pkg::COORD_BITS-1:0]         mag;
   logic [2*salt_pkg::COORD_BITS-1:0]       mag_sq;
   logic [salt_pkg::REM_BITS-1:0]           rem_sh;
   logic [salt_pkg::REM_BITS-1:0]           trial;
   logic [salt_pkg::ARC_BITS:0]             arc_sum;
   logic [salt_pkg::ARC_BITS-1:0]           arc_sat;
   logic                                    req_xfer;
   logic                                    out_free;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_xfer   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   // Clamp the dimension count into its legal range
   always_comb begin
      if (dims_ff < salt_pkg::DIMS_MIN) begin
         dims_eff = salt_pkg::DIMS_MIN;
      end else if (dims_ff > salt_pkg::DIMS_BITS'(salt_pkg::MAX_DIMS)) begin
         dims_eff = salt_pkg::DIMS_BITS'(salt_pkg::MAX_DIMS);
      end else begin
         dims_eff = dims_ff;
      end
   end

   assign last_dim = salt_pkg::DIM_IDX_BITS'(dims_eff - salt_pkg::DIMS_BITS'(1));

   // Shared multiply-accumulate unit
   assign diff     = salt_pkg::DIFF_BITS'(pt_ff[dim_ff]) - salt_pkg::DIFF_BITS'(last_ff[dim_ff]);
   assign diff_abs = diff[salt_pkg::DIFF_BITS-1] ? salt_pkg::DIFF_BITS'(-diff)
                                                 : salt_pkg::DIFF_BITS'(diff);
   assign mag      = diff_abs[salt_pkg::COORD_BITS-1:0];
   assign mag_sq   = mag * mag;

   // One restoring square root step
   assign rem_sh = {rem_ff[salt_pkg::REM_BITS-3:0], rad_ff[salt_pkg::RAD_BITS-1 -: 2]};
   assign trial  = salt_pkg::REM_BITS'({root_ff, 2'b01});

   // Saturating arc length
   assign arc_sum = {1'b0, run_ff} + (salt_pkg::ARC_BITS+1)'(root_ff);
   assign arc_sat = arc_sum[salt_pkg::ARC_BITS] ? '1 : arc_sum[salt_pkg::ARC_BITS-1:0];

   always_comb begin
      state_in     = state_ff;
      dim_in       = dim_ff;
      cnt_in       = cnt_ff;
      first_in     = first_ff;
      keep_in      = keep_ff;
      rsp_valid_in = rsp_valid_ff;
      dims_in      = dims_ff;
      min_sq_in    = min_sq_ff;
      last_in      = last_ff;
      run_in       = run_ff;
      kept_in      = kept_ff;
      pt_in        = pt_ff;
      acc_in       = acc_ff;
      rad_in       = rad_ff;
      rem_in       = rem_ff;
      root_in      = root_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;

      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            salt_pkg::CSR_DIMS_IN_USE: begin
               dims_in = csr_wdata[salt_pkg::DIMS_BITS-1:0];
            end
            salt_pkg::CSR_MIN_SQ_DISTANCE: begin
               min_sq_in = csr_wdata[salt_pkg::MIN_SQ_BITS-1:0];
            end
            default: begin
            end
         endcase
      end

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               for (int k = 0; k < salt_pkg::MAX_DIMS; k++) begin
                  if (k < salt_pkg::NUM_IN_COORDS) begin
                     pt_in[k] = req_tdata[k*salt_pkg::COORD_BITS +: salt_pkg::COORD_BITS];
                  end else begin
                     pt_in[k] = '0;
                  end
               end
               first_in = req_tuser || (kept_ff == '0);
               keep_in  = 1'b0;
               acc_in   = '0;
               dim_in   = '0;
               state_in = (req_tuser || (kept_ff == '0)) ? ST_DONE : ST_SQ;
            end
         end
         ST_SQ: begin
            acc_in = acc_ff + salt_pkg::SQ_BITS'(mag_sq);
            dim_in = dim_ff + 1'b1;
            if (dim_ff == last_dim) begin
               state_in = ST_CMP;
            end
         end
         ST_CMP: begin
            rad_in  = salt_pkg::RAD_BITS'(acc_ff);
            rem_in  = '0;
            root_in = '0;
            cnt_in  = '0;
            if (salt_pkg::MIN_SQ_BITS'(acc_ff) > min_sq_ff) begin
               keep_in  = 1'b1;
               state_in = ST_ROOT;
            end else begin
               keep_in  = 1'b0;
               state_in = ST_DONE;
            end
         end
         ST_ROOT: begin
            rad_in = {rad_ff[salt_pkg::RAD_BITS-3:0], 2'b00};
            if (rem_sh >= trial) begin
               rem_in  = rem_sh - trial;
               root_in = {root_ff[salt_pkg::ROOT_BITS-2:0], 1'b1};
            end else begin
               rem_in  = rem_sh;
               root_in = {root_ff[salt_pkg::ROOT_BITS-2:0], 1'b0};
            end
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == ROOT_LAST_CNT) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            // Hold until the output register is free
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = '0;
               if (first_ff) begin
                  rsp_user_in = 1'b1;
                  last_in     = pt_ff;
                  run_in      = '0;
                  kept_in     = salt_pkg::INDEX_BITS'(1);
               end else if (keep_ff) begin
                  rsp_user_in = 1'b1;
                  rsp_data_in[salt_pkg::RSP_INDEX_LSB +: salt_pkg::INDEX_BITS] = kept_ff;
                  rsp_data_in[salt_pkg::RSP_SEG_LSB +: salt_pkg::SEG_BITS] =
                     salt_pkg::SEG_BITS'(root_ff);
                  rsp_data_in[salt_pkg::RSP_ARC_LSB +: salt_pkg::ARC_BITS] = arc_sat;
                  last_in = pt_ff;
                  run_in  = arc_sat;
                  if (kept_ff != INDEX_MAX) begin
                     kept_in = kept_ff + 1'b1;
                  end
               end else begin
                  rsp_user_in = 1'b0;
                  rsp_data_in[salt_pkg::RSP_INDEX_LSB +: salt_pkg::INDEX_BITS] =
                     kept_ff - 1'b1;
                  rsp_data_in[salt_pkg::RSP_ARC_LSB +: salt_pkg::ARC_BITS] = run_ff;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         dim_ff       <= '0;
         cnt_ff       <= '0;
         first_ff     <= 1'b0;
         keep_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         dims_ff      <= salt_pkg::DIMS_RESET;
         min_sq_ff    <= '0;
         run_ff       <= '0;
         kept_ff      <= '0;
         for (int k = 0; k < salt_pkg::MAX_DIMS; k++) begin
            last_ff[k] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         dim_ff       <= dim_in;
         cnt_ff       <= cnt_in;
         first_ff     <= first_in;
         keep_ff      <= keep_in;
         rsp_valid_ff <= rsp_valid_in;
         dims_ff      <= dims_in;
         min_sq_ff    <= min_sq_in;
         run_ff       <= run_in;
         kept_ff      <= kept_in;
         last_ff      <= last_in;
      end
   end

   always_ff @(posedge clock) begin
      pt_ff       <= pt_in;
      acc_ff      <= acc_in;
      rad_ff      <= rad_in;
      rem_ff      <= rem_in;
      root_ff     <= root_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

endmodule : stroke_arc_length_tracker_top

`default_nettype wire

### src/salt_checker.sv
// ---------------------------------------------------------------------------
// Stroke arc-length tracker port checker
// Watches the top-level ports for result consistency and stream handshake.
// ---------------------------------------------------------------------------
`default_nettype none

module salt_checker (
   input wire logic                                  clock,
   input wire logic                                  reset,
   input wire logic                                  req_tvalid,
   input wire logic                                  req_tready,
   input wire logic                                  rsp_tvalid,
   input wire logic                                  rsp_tready,
   input wire logic [salt_pkg::RSP_TDATA_BITS-1:0]   rsp_tdata,
   input wire logic                                  rsp_tuser
);

   logic [salt_pkg::INDEX_BITS-1:0] idx;
   logic [salt_pkg::SEG_BITS-1:0]   seg;
   logic [salt_pkg::ARC_BITS-1:0]   arc;

   assign idx = rsp_tdata[salt_pkg::RSP_INDEX_LSB +: salt_pkg::INDEX_BITS];
   assign seg = rsp_tdata[salt_pkg::RSP_SEG_LSB +: salt_pkg::SEG_BITS];
   assign arc = rsp_tdata[salt_pkg::RSP_ARC_LSB +: salt_pkg::ARC_BITS];

   // A stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result changed while stalled");

   // A point in progress blocks the input
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("input ready right after a transfer");

   // A dropped point carries no segment
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> seg == '0)
      else $error("dropped point with nonzero segment length");

   // The first point of a stroke starts from zero length
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser && idx == '0 |-> seg == '0 && arc == '0)
      else $error("stroke start with nonzero length");

endmodule : salt_checker

bind stroke_arc_length_tracker_top salt_checker u_salt_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

`default_nettype wire

### sim/stroke_arc_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Stroke arc-length checker
// Watches the point, result and register channels of the tracker, follows the
// stroke on its own copy of the state and compares every result field.
// ---------------------------------------------------------------------------

module stroke_arc_checker
   import salt_pkg::*;
(
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_tvalid,
   input  wire logic                        req_tready,
   input  wire logic [REQ_TDATA_BITS-1:0]   req_tdata,
   input  wire logic                        req_tuser,
   input  wire logic                        rsp_tvalid,
   input  wire logic                        rsp_tready,
   input  wire logic [RSP_TDATA_BITS-1:0]   rsp_tdata,
   input  wire logic                        rsp_tuser,
   input  wire logic                        csr_valid,
   input  wire logic                        csr_ready,
   input  wire logic [CSR_INDEX_BITS-1:0]   csr_index,
   input  wire logic [CSR_DATA_BITS-1:0]    csr_wdata,
   output int                               points_in_flight,
   output int                               mismatch_count
);

   typedef struct packed {
      logic                  accepted;
      logic [INDEX_BITS-1:0] point_index;
      logic [SEG_BITS-1:0]   segment_length;
      logic [ARC_BITS-1:0]   arc_length;
   } stroke_result_type;

   logic [DIMS_BITS-1:0]   dims_reg;
   logic [MIN_SQ_BITS-1:0] min_sq_reg;
   coord_type              anchor [MAX_DIMS];
   logic [ARC_BITS-1:0]    arc_total;
   logic [INDEX_BITS-1:0]  kept_points;
   stroke_result_type      predicted_results [$];
   int                     fault_total = 0;

   // Bit-by-bit search for the largest root whose square fits
   function automatic logic [SEG_BITS-1:0] floor_sqrt(input logic [63:0] value);
      logic [SEG_BITS-1:0] root;
      logic [SEG_BITS-1:0] trial;
      root = '0;
      for (int b = SEG_BITS - 1; b >= 0; b--) begin
         trial = root | (SEG_BITS'(1) << b);
         if (64'(trial) * 64'(trial) <= value)
            root = trial;
      end
      return root;
   endfunction

   function automatic stroke_result_type follow_point(input logic start,
                                                      input logic [REQ_TDATA_BITS-1:0] coords);
      stroke_result_type res;
      coord_type         pt [MAX_DIMS];
      int unsigned       used;
      longint            delta;
      logic [63:0]       dist_sq;
      logic [ARC_BITS:0] sum;
      for (int k = 0; k < MAX_DIMS; k++)
         pt[k] = coords[k*COORD_BITS +: COORD_BITS];
      // Out-of-range dimension settings clamp to the supported span
      if (dims_reg < DIMS_MIN)
         used = DIMS_MIN;
      else if (dims_reg > MAX_DIMS)
         used = MAX_DIMS;
      else
         used = dims_reg;
      res = '0;
      if (start || kept_points == '0) begin
         anchor      = pt;
         arc_total   = '0;
         kept_points = INDEX_BITS'(1);
         res.accepted = 1'b1;
         return res;
      end
      dist_sq = '0;
      for (int k = 0; k < used; k++) begin
         delta   = longint'(pt[k]) - longint'(anchor[k]);
         dist_sq = dist_sq + 64'(delta * delta);
      end
      if (dist_sq > 64'(min_sq_reg)) begin
         res.accepted       = 1'b1;
         res.point_index    = kept_points;
         res.segment_length = floor_sqrt(dist_sq);
         sum       = {1'b0, arc_total} + (ARC_BITS + 1)'(res.segment_length);
         arc_total = sum[ARC_BITS] ? '1 : sum[ARC_BITS-1:0];
         res.arc_length = arc_total;
         anchor = pt;
         if (kept_points != '1)
            kept_points = kept_points + 1'b1;
      end else begin
         // Drop: report the last kept point, leave the state alone
         res.point_index = kept_points - 1'b1;
         res.arc_length  = arc_total;
      end
      return res;
   endfunction

   function automatic int field_check(input string label, input logic [63:0] want,
                                      input logic [63:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, actual %0d", label, want, got);
         return 1;
      end
      return 0;
   endfunction

   always @(posedge clock) begin : watch
      stroke_result_type want;
      if (reset) begin
         dims_reg    = DIMS_RESET;
         min_sq_reg  = '0;
         anchor      = '{default: '0};
         arc_total   = '0;
         kept_points = '0;
         predicted_results.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_DIMS_IN_USE)
               dims_reg = csr_wdata[DIMS_BITS-1:0];
            else if (csr_index == CSR_MIN_SQ_DISTANCE)
               min_sq_reg = csr_wdata[MIN_SQ_BITS-1:0];
         end
         if (rsp_tvalid && rsp_tready) begin
            if (predicted_results.size() == 0) begin
               $error("result transfer with no point outstanding");
               fault_total++;
            end else begin
               want = predicted_results.pop_front();
               fault_total += field_check("accepted", want.accepted, rsp_tuser);
               fault_total += field_check("point_index", want.point_index,
                                          rsp_tdata[RSP_INDEX_LSB +: INDEX_BITS]);
               fault_total += field_check("segment_length", want.segment_length,
                                          rsp_tdata[RSP_SEG_LSB +: SEG_BITS]);
               fault_total += field_check("arc_length", want.arc_length,
                                          rsp_tdata[RSP_ARC_LSB +: ARC_BITS]);
            end
         end
         if (req_tvalid && req_tready)
            predicted_results.push_back(follow_point(req_tuser, req_tdata));
      end
      points_in_flight <= predicted_results.size();
      mismatch_count   <= fault_total;
   end

endmodule

### sim/tb_stroke_arc_length_tracker_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Stroke arc-length tracker testbench
// Drives directed and random strokes under several register settings, with
// random gaps on both streams, one long result stall and one stroke that
// bounces between opposite corners. The checker compares.
// ---------------------------------------------------------------------------

module tb_stroke_arc_length_tracker_top;
   import salt_pkg::*;

   localparam int STALL_LIMIT        = 5000;
   localparam int RSP_HOLD_CYCLES    = 300;
   localparam int SETTLE_CYCLES      = 40;
   localparam int LONG_STROKE_POINTS = 40;
   localparam int PHASE_COUNT        = 11;
   localparam int PHASE_POINTS       = 105;

   logic                       clock;
   logic                       reset;
   logic                       req_tvalid;
   logic                       req_tready;
   logic [REQ_TDATA_BITS-1:0]  req_tdata;
   logic                       req_tuser;
   logic                       rsp_tvalid;
   logic                       rsp_tready;
   logic [RSP_TDATA_BITS-1:0]  rsp_tdata;
   logic                       rsp_tuser;
   logic                       csr_valid;
   logic                       csr_ready;
   logic [CSR_INDEX_BITS-1:0]  csr_index;
   logic [CSR_DATA_BITS-1:0]   csr_wdata;

   int points_in_flight;
   int mismatch_count;
   int idle_cycles = 0;
   bit req_quiet     = 1'b0;
   bit rsp_quiet     = 1'b0;
   bit hold_results  = 1'b0;

   initial clock = 1'b0;
   always #4 clock = ~clock;

   stroke_arc_length_tracker_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   stroke_arc_checker arc_check (
      .clock            (clock),
      .reset            (reset),
      .req_tvalid       (req_tvalid),
      .req_tready       (req_tready),
      .req_tdata        (req_tdata),
      .req_tuser        (req_tuser),
      .rsp_tvalid       (rsp_tvalid),
      .rsp_tready       (rsp_tready),
      .rsp_tdata        (rsp_tdata),
      .rsp_tuser        (rsp_tuser),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .points_in_flight (points_in_flight),
      .mismatch_count   (mismatch_count)
   );

   // Watchdog: any transfer on any channel restarts the count
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("stroke_arc_length_tracker_top verification failed");
         $finish;
      end
   end

   // Result side: random stalls per transfer, one long hold on request
   initial begin : result_sink
      int unsigned gap;
      rsp_tready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_results) begin
            hold_results = 1'b0;
            rsp_tready <= 1'b0;
            for (int n = 0; n < RSP_HOLD_CYCLES; n++)
               @(posedge clock);
         end
         gap = rsp_quiet ? 0 : $urandom_range(0, 6);
         if (gap != 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!(rsp_tvalid && rsp_tready)) @(posedge clock);
      end
   end

   task automatic send_point(input logic start, input coord_type c0, input coord_type c1,
                             input coord_type c2, input coord_type c3);
      int unsigned gap;
      gap = req_quiet ? 0 : $urandom_range(0, 6);
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= start;
      req_tdata  <= {c3, c2, c1, c0};
      @(posedge clock);
      while (!(req_tvalid && req_tready)) @(posedge clock);
   endtask

   // Stop offering points and wait for every outstanding result
   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (points_in_flight != 0) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_BITS-1:0] index,
                            input logic [CSR_DATA_BITS-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      while (!(csr_valid && csr_ready)) @(posedge clock);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // Mostly random walks from a stroke start, plus repeats and noise points
   task automatic run_phase(input int unsigned n_points);
      coord_type   walk [MAX_DIMS];
      int unsigned pick;
      int unsigned span;
      walk = '{default: '0};
      for (int unsigned i = 0; i < n_points; i++) begin
         if (i % 25 == 0) begin
            req_quiet = ($urandom_range(0, 3) == 0);
            rsp_quiet = ($urandom_range(0, 3) == 0);
         end
         pick = $urandom_range(0, 99);
         if (i == 0 || pick < 6) begin
            for (int k = 0; k < MAX_DIMS; k++)
               walk[k] = coord_type'($urandom);
            send_point(1'b1, walk[0], walk[1], walk[2], walk[3]);
         end else if (pick < 14) begin
            send_point(1'($urandom_range(0, 1)), coord_type'($urandom), coord_type'($urandom),
                       coord_type'($urandom), coord_type'($urandom));
         end else if (pick < 24) begin
            send_point(1'b0, walk[0], walk[1], walk[2], walk[3]);
         end else begin
            span = (pick < 50) ? 3 : (pick < 75) ? 7 : (pick < 92) ? 12 : 16;
            for (int k = 0; k < MAX_DIMS; k++)
               walk[k] = walk[k] + coord_type'($urandom_range(0, (1 << span) - 1) -
                                               (1 << (span - 1)));
            send_point(1'b0, walk[0], walk[1], walk[2], walk[3]);
         end
      end
      drain();
   endtask

   initial begin : stimulus
      logic [CSR_DATA_BITS-1:0] min_sq;
      int unsigned              dims_sel;
      int unsigned              min_sel;
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tuser  <= 1'b0;
      req_tdata  <= '0;
      csr_valid  <= 1'b0;
      csr_index  <= CSR_DIMS_IN_USE;
      csr_wdata  <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // First point after reset, repeat in the used plane, extreme 2-D jump
      send_point(1'b0, -32768, 32767, 16'h1234, -1);
      send_point(1'b0, -32768, 32767, 5, 5);
      send_point(1'b0, 32767, -32768, 0, 0);
      send_point(1'b0, 32767, -32767, 0, 0);
      send_point(1'b1, 100, 100, 0, 0);
      send_point(1'b0, 103, 104, 0, 0);
      drain();
      // Largest possible segment over four coordinates
      write_csr(CSR_DIMS_IN_USE, 4);
      send_point(1'b1, -32768, -32768, -32768, -32768);
      send_point(1'b0, 32767, 32767, 32767, 32767);
      send_point(1'b0, 32767, 32767, 32767, 32766);
      drain();
      write_csr(CSR_DIMS_IN_USE, 3);
      send_point(1'b0, 32767, 32767, 32766, 0);
      drain();
      // Dimension settings below and above the supported range
      write_csr(CSR_DIMS_IN_USE, 0);
      send_point(1'b0, 32767, 32766, -5, 7);
      drain();
      write_csr(CSR_DIMS_IN_USE, 7);
      send_point(1'b0, 32767, 32766, -5, 9);
      drain();
      write_csr(CSR_DIMS_IN_USE, 5);
      send_point(1'b0, 32767, 32766, -5, 9);
      drain();
      // Distance exactly at the threshold drops, just above it keeps
      write_csr(CSR_DIMS_IN_USE, 2);
      write_csr(CSR_MIN_SQ_DISTANCE, 25);
      send_point(1'b1, 0, 0, 0, 0);
      send_point(1'b0, 3, 4, 0, 0);
      send_point(1'b0, 3, 5, 0, 0);
      send_point(1'b0, -3, -3, 0, 0);
      drain();
      write_csr(CSR_MIN_SQ_DISTANCE, '1);
      send_point(1'b0, -32768, -32768, 0, 0);
      send_point(1'b1, 1, 1, 0, 0);
      send_point(1'b0, 32767, -32768, 0, 0);
      drain();
      write_csr(CSR_MIN_SQ_DISTANCE, 0);

      // One stroke bouncing between opposite corners, back to back
      req_quiet = 1'b1;
      rsp_quiet = 1'b1;
      for (int n = 0; n < LONG_STROKE_POINTS; n++) begin
         if (n[0])
            send_point(1'b0, 32767, 32767, 0, 0);
         else
            send_point(n == 0, -32768, -32768, 0, 0);
      end
      send_point(1'b0, 32767, 32767, 0, 0);
      send_point(1'b0, -32768, -32768, 0, 0);
      drain();

      for (int p = 0; p < PHASE_COUNT; p++) begin
         dims_sel = (p < 3) ? 2 + p : $urandom_range(0, 7);
         min_sel  = (p < 2) ? p * 4 : $urandom_range(0, 4);
         case (min_sel)
            0:       min_sq = '0;
            1:       min_sq = CSR_DATA_BITS'($urandom_range(1, 64));
            2:       min_sq = CSR_DATA_BITS'($urandom_range(0, 1 << 24));
            3:       min_sq = CSR_DATA_BITS'({$urandom, $urandom});
            default: min_sq = '1;
         endcase
         // Upper bits of the dimension write carry noise
         write_csr(CSR_DIMS_IN_USE,
                   {CSR_DATA_BITS'({$urandom, $urandom}) >> DIMS_BITS << DIMS_BITS} |
                   CSR_DATA_BITS'(dims_sel));
         write_csr(CSR_MIN_SQ_DISTANCE, min_sq);
         if (p == 4)
            hold_results = 1'b1;
         run_phase(PHASE_POINTS);
      end

      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && points_in_flight == 0)
         $display("stroke_arc_length_tracker_top verification clean");
      else
         $display("stroke_arc_length_tracker_top verification failed");
      $finish;
   end

endmodule
